FILE: src/tlbw_pkg.sv
`timescale 1ns / 1ps
package tlbw_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int ADDR_W    = 32;
	localparam int OFFSET_W  = 12;
	localparam int TAG_W     = ADDR_W - OFFSET_W;
	localparam int DIR_SHIFT = 22;
	localparam int LFSR_W    = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 8'h01;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 8'hB8;

	localparam logic [CFG_IDX_W-1:0] REG_PAGING_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_DIR_BASE = 1'b1;

	localparam logic [1:0] MODE_TRANSLATE = 2'd0;
	localparam logic [1:0] MODE_REPLY     = 2'd1;
	localparam logic [1:0] MODE_FLUSH     = 2'd2;

	localparam logic [2:0] KIND_PHYS  = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_FAULT = 3'd2;
	localparam logic [2:0] KIND_FLUSH = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] linear_addr;
		logic [ADDR_W-1:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] address;
	} out_item_t;

	typedef enum logic [1:0] {
		WALK_IDLE = 2'd0,
		WALK_DIR  = 2'd1,
		WALK_TBL  = 2'd2
	} walk_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_PASS,
		OP_HIT,
		OP_DIR_REQ,
		OP_TBL_REQ,
		OP_FILL,
		OP_FAULT,
		OP_FLUSH,
		OP_ERR_LIN,
		OP_ERR_PEND
	} op_t;

	typedef struct packed {
		logic       capture;
		logic       commit;
		op_t        op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       walking;
		logic       at_dir;
		logic       paging;
		logic       hit;
		logic       present;
	} dp_status_t;

	// lowest set bit of a vector
	function automatic logic [IDX_W-1:0] first_one(input logic [ENTRIES-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: src/tlb_with_two_level_page_walk.sv
`timescale 1ns / 1ps
// the transaction is captured by the lookup registers, then the execute step
// commits its result to the output register; lookup (tag compare plus frame
//   memory read) and execute/commit share a single in-flight slot
// a stalled result holds the execute step until the output register drains
// reset: valid bits cleared at once, walk idle, victim lfsr = 1, paging off
module tlb_with_two_level_page_walk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tlbw_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tlbw_pkg::out_item_t            out_item,
	input  logic                           cfg_we,
	input  logic [tlbw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlbw_pkg::ADDR_W-1:0]    cfg_wdata
);
	import tlbw_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	tlbw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tlbw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: src/tlbw_ctrl.sv
`timescale 1ns / 1ps
module tlbw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  tlbw_pkg::dp_status_t status,
	output tlbw_pkg::dp_cmd_t    cmd
);
	import tlbw_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;
	op_t         op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// decode the operation for the captured transaction
	always_comb begin
		case (status.mode)
			MODE_TRANSLATE: begin
				if (status.walking) begin
					op = OP_ERR_LIN;
				end else if (!status.paging) begin
					op = OP_PASS;
				end else if (status.hit) begin
					op = OP_HIT;
				end else begin
					op = OP_DIR_REQ;
				end
			end
			MODE_REPLY: begin
				if (!status.walking) begin
					op = OP_ERR_PEND;
				end else if (!status.present) begin
					op = OP_FAULT;
				end else if (status.at_dir) begin
					op = OP_TBL_REQ;
				end else begin
					op = OP_FILL;
				end
			end
			MODE_FLUSH: op = OP_FLUSH;
			default:    op = OP_ERR_LIN;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && out_stall;
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		cmd.op      = op;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// result register must be free or draining this cycle
				if (!out_valid_q || !out_stall) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while one is in flight");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");
`endif

endmodule

FILE: src/tlbw_dp.sv
`timescale 1ns / 1ps
module tlbw_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlbw_pkg::in_item_t   in_item,
	output tlbw_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic [tlbw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlbw_pkg::ADDR_W-1:0]    cfg_wdata,
	input  tlbw_pkg::dp_cmd_t    cmd,
	output tlbw_pkg::dp_status_t status
);
	import tlbw_pkg::*;

	logic                paging_q;
	logic [ADDR_W-1:0]   base_q;

	logic [ENTRIES-1:0]  valid_q;
	logic [TAG_W-1:0]    tag_q [ENTRIES];
	logic [TAG_W-1:0]    frame_mem [ENTRIES];

	walk_t               walk_q;
	logic [ADDR_W-1:0]   pend_q;
	logic [LFSR_W-1:0]   lfsr_q;

	logic [1:0]          mode_q;
	logic [ADDR_W-1:0]   lin_q;
	logic [ADDR_W-1:0]   data_q;
	logic                hit_q;
	logic [TAG_W-1:0]    frame_rd_q;
	out_item_t           out_q;

	logic [ENTRIES-1:0]  hit_vec;
	logic [IDX_W-1:0]    hit_idx;
	logic                has_free;
	logic [IDX_W-1:0]    slot;
	logic                do_fill;
	logic                walking;
	out_item_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAGING_ENABLE: paging_q <= cfg_wdata[0];
				REG_PAGE_DIR_BASE: base_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// tag compare across all lanes against the incoming address
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (tag_q[i] == in_item.linear_addr[ADDR_W-1:OFFSET_W]);
		end
	end

	assign hit_idx  = first_one(hit_vec);
	assign has_free = ~&valid_q;
	assign slot     = has_free ? first_one(~valid_q)
	                           : IDX_W'({1'b0, lfsr_q} % (LFSR_W + 1)'(ENTRIES));
	assign do_fill  = cmd.commit && (cmd.op == OP_FILL);
	assign walking  = (walk_q == WALK_DIR) || (walk_q == WALK_TBL);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_item.mode;
			lin_q  <= in_item.linear_addr;
			data_q <= in_item.read_data;
			hit_q  <= |hit_vec;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
		if (do_fill) begin
			tag_q[slot] <= pend_q[ADDR_W-1:OFFSET_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_rd_q <= frame_mem[hit_idx];
		end
		if (do_fill) begin
			frame_mem[slot] <= data_q[ADDR_W-1:OFFSET_W];
		end
	end

	always_comb begin
		res.kind    = KIND_ERROR;
		res.address = lin_q;
		case (cmd.op)
			OP_PASS: res.kind = KIND_PHYS;
			OP_HIT: begin
				res.kind    = KIND_PHYS;
				res.address = {frame_rd_q, lin_q[OFFSET_W-1:0]};
			end
			OP_DIR_REQ: begin
				res.kind    = KIND_READ;
				res.address = {base_q[ADDR_W-1:OFFSET_W], OFFSET_W'(0)}
				            + {(DIR_SHIFT - 2)'(0), lin_q[ADDR_W-1:DIR_SHIFT], 2'b00};
			end
			OP_TBL_REQ: begin
				res.kind    = KIND_READ;
				res.address = {data_q[ADDR_W-1:OFFSET_W], OFFSET_W'(0)}
				            + {(ADDR_W - DIR_SHIFT + OFFSET_W - 2)'(0),
				               pend_q[DIR_SHIFT-1:OFFSET_W], 2'b00};
			end
			OP_FILL: begin
				res.kind    = KIND_PHYS;
				res.address = {data_q[ADDR_W-1:OFFSET_W], pend_q[OFFSET_W-1:0]};
			end
			OP_FAULT: begin
				res.kind    = KIND_FAULT;
				res.address = pend_q;
			end
			OP_FLUSH:    res.kind = KIND_FLUSH;
			OP_ERR_LIN:  res.kind = KIND_ERROR;
			OP_ERR_PEND: begin
				res.kind    = KIND_ERROR;
				res.address = pend_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			walk_q  <= WALK_IDLE;
			pend_q  <= '0;
			lfsr_q  <= LFSR_SEED;
		end else if (cmd.commit) begin
			case (cmd.op)
				OP_PASS, OP_HIT: walk_q <= WALK_IDLE;
				OP_DIR_REQ: begin
					walk_q <= WALK_DIR;
					pend_q <= lin_q;
				end
				OP_TBL_REQ: walk_q <= WALK_TBL;
				OP_FAULT:   walk_q <= WALK_IDLE;
				OP_FILL: begin
					walk_q        <= WALK_IDLE;
					valid_q[slot] <= 1'b1;
					if (!has_free) begin
						lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
					end
				end
				OP_FLUSH: begin
					walk_q  <= WALK_IDLE;
					valid_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status.mode    = mode_q;
		status.walking = walking;
		status.at_dir  = (walk_q == WALK_DIR);
		status.paging  = paging_q;
		status.hit     = hit_q;
		status.present = data_q[0];
	end

	assign out_item = out_q;

`ifndef NO_ASSERTIONS
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("tag present in more than one entry");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && cmd.op == OP_FLUSH |=> valid_q == '0)
		else $error("flush left valid entries");

	a_fill_at_table: assert property (@(posedge clk) disable iff (!arst_n)
		do_fill |-> walk_q == WALK_TBL)
		else $error("fill outside the table phase of a walk");
`endif

endmodule
